FILE: rtl/conv3_pkg.sv
// Shared constants, register codes and helpers for the 3x3 convolution block.
// Used by conv3x3_zero_pad_clamp and its checker conv3_chk; no dependencies.
package conv3_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned DimW     = 12;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned CoefNum  = 3;
  localparam int unsigned CfgW     = CoefW * CoefNum;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned EntryW   = 2 * PixW;

  localparam int unsigned MaxWidthDef     = 2048;
  localparam int unsigned CoefFracBitsDef = 8;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgCoefTop = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefMid = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefBot = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWidth   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHeight  = 3'd4;

  localparam logic [CfgW-1:0] CoefTopRst = 48'h0000_0000_0000;
  localparam logic [CfgW-1:0] CoefMidRst = 48'h0000_0100_0000;
  localparam logic [CfgW-1:0] CoefBotRst = 48'h0000_0000_0000;
  localparam logic [DimW-1:0] WidthRst   = 12'd640;
  localparam logic [DimW-1:0] HeightRst  = 12'd480;

  typedef logic [PixW-1:0] pix_t;

  // Result tags that travel alongside a pixel through the datapath
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } tag_t;

  // Which kernel rows and columns lie inside the image
  typedef struct packed {
    logic [CoefNum-1:0] row_ok;
    logic [CoefNum-1:0] col_ok;
  } tap_ok_t;

  // Pick coefficient k (0 = left) out of one packed kernel row
  function automatic logic signed [CoefW-1:0] coef_at(input logic [CfgW-1:0] row,
                                                      input int unsigned k);
    coef_at = $signed(row[CoefW*k +: CoefW]);
  endfunction

endpackage

FILE: rtl/conv3x3_zero_pad_clamp.sv
// 3x3 convolution with zero padding, clamp to 0..255 and truncation.
// A result passes the stage-1, tap, product, row-sum and output registers in turn.
// Throughput: one input per cycle unless stalled; line store: one read and one write.
// Stalls on the output back up through a 5-stage chain with per-stage valid bits.
// Reset: counters, window and kernel registers reset at once; the line store is
// never cleared, since entries are written before any unmasked read.
// Depends on conv3_pkg.
module conv3x3_zero_pad_clamp #(
  parameter int unsigned MaxWidth     = conv3_pkg::MaxWidthDef,
  parameter int unsigned CoefFracBits = conv3_pkg::CoefFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [conv3_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [conv3_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [conv3_pkg::PixW-1:0]    pixel_in_i,
  input  logic                          is_pad_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [conv3_pkg::PixW-1:0]    pixel_out_o,
  output logic                          row_end_o,
  output logic                          frame_end_o
);
  import conv3_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned ProdW = CoefW + PixW + 1;
  localparam int unsigned RowW  = ProdW + 2;
  localparam int unsigned SumW  = RowW + 2;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] coef_q [CoefNum];
  logic [DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= CoefTopRst;
      coef_q[1] <= CoefMidRst;
      coef_q[2] <= CoefBotRst;
      width_q   <= WidthRst;
      height_q  <= HeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCoefTop: coef_q[0] <= cfg_wdata_i;
        CfgCoefMid: coef_q[1] <= cfg_wdata_i;
        CfgCoefBot: coef_q[2] <= cfg_wdata_i;
        CfgWidth:   width_q   <= cfg_wdata_i[DimW-1:0];
        CfgHeight:  height_q  <= cfg_wdata_i[DimW-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Last column and last row after range fixing: zero means one, width caps at MaxWidth
  logic [DimW-1:0] w_last, h_last;

  always_comb begin
    if (width_q == '0) begin
      w_last = '0;
    end else if (int'(width_q) > int'(MaxWidth)) begin
      w_last = DimW'(MaxWidth - 1);
    end else begin
      w_last = width_q - 1'b1;
    end
    h_last = (height_q == '0) ? '0 : height_q - 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: each stage advances when the one after it has room
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_emit_q;
  logic s1_go, s2_go, s3_go, s4_go;
  logic s2_rdy, s3_rdy, s4_rdy, out_rdy;
  logic in_acc;

  assign out_rdy    = !out_v_q || out_ready_i;
  assign s4_go      = s4_v_q && out_rdy;
  assign s4_rdy     = !s4_v_q || s4_go;
  assign s3_go      = s3_v_q && s4_rdy;
  assign s3_rdy     = !s3_v_q || s3_go;
  assign s2_go      = s2_v_q && s3_rdy;
  assign s2_rdy     = !s2_v_q || s2_go;
  // A transaction with no result leaves the chain once its line-store write is done
  assign s1_go      = s1_v_q && (!s1_emit_q || s2_rdy);
  assign in_ready_o = !s1_v_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Stage 0: position counters, read address, result decision
  // ---------------------------------------------------------------------------
  logic [DimW-1:0]  in_col_q, in_row_q, out_col_q, out_row_q;
  logic [DimW-1:0]  in_col_d, in_row_d, out_col_d, out_row_d;
  logic [AddrW-1:0] rd_addr;
  logic             emit, rend, fend;
  tap_ok_t          tap_ok;

  assign emit = (in_row_q >= DimW'(2)) || (in_row_q == DimW'(1) && in_col_q != '0);
  assign rend = out_col_q >= w_last;
  assign fend = rend && (out_row_q >= h_last);

  assign tap_ok.row_ok = {out_row_q < h_last, 1'b1, out_row_q != '0};
  assign tap_ok.col_ok = {out_col_q < w_last, 1'b1, out_col_q != '0};

  always_comb begin
    if (int'(in_col_q) < int'(MaxWidth)) begin
      rd_addr = AddrW'(in_col_q);
    end else begin
      rd_addr = AddrW'(MaxWidth - 1);
    end
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (in_acc) begin
      // Wrap the input column; hold the row at its ceiling
      if (in_col_q >= w_last) begin
        in_col_d = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + 1'b1;
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (emit) begin
        if (fend) begin
          // Frame complete: restart every position
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (rend) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: per column, upper byte two rows above, lower byte one row above
  // ---------------------------------------------------------------------------
  logic [EntryW-1:0] line_mem [MaxWidth];
  logic [EntryW-1:0] rd_data_q;
  logic [EntryW-1:0] entry, wr_data;
  logic [EntryW-1:0] fwd_data_q;
  logic              fwd_q;
  logic [AddrW-1:0]  s1_addr_q;
  pix_t              s1_px_q;
  tap_ok_t           s1_ok_q;
  tag_t              s1_tag_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= line_mem[rd_addr];
    end
    if (s1_go) begin
      line_mem[s1_addr_q] <= wr_data;
    end
  end

  // Forward the write of the transaction ahead when both touch the same column
  assign entry   = fwd_q ? fwd_data_q : rd_data_q;
  assign wr_data = {entry[PixW-1:0], s1_px_q};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_q      <= s1_go && (s1_addr_q == rd_addr);
      fwd_data_q <= wr_data;
      s1_addr_q  <= rd_addr;
      s1_px_q    <= is_pad_i ? '0 : pixel_in_i;
      s1_ok_q    <= tap_ok;
      s1_tag_q   <= '{row_end: rend, frame_end: fend};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: shift the window and capture masked taps
  // ---------------------------------------------------------------------------
  pix_t win_q [CoefNum][CoefNum];
  pix_t win_d [CoefNum][CoefNum];
  pix_t tap_q [CoefNum][CoefNum];
  tag_t s2_tag_q;

  always_comb begin
    for (int r = 0; r < CoefNum; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = entry[EntryW-1:PixW];
    win_d[1][2] = entry[PixW-1:0];
    win_d[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < CoefNum; r++) begin
        for (int c = 0; c < CoefNum; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_go) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit_q) begin
      for (int r = 0; r < CoefNum; r++) begin
        for (int c = 0; c < CoefNum; c++) begin
          tap_q[r][c] <= (s1_ok_q.row_ok[r] && s1_ok_q.col_ok[c]) ? win_d[r][c] : '0;
        end
      end
      s2_tag_q <= s1_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: nine coefficient by pixel products
  // ---------------------------------------------------------------------------
  logic signed [ProdW-1:0] prod_q [CoefNum][CoefNum];
  tag_t                    s3_tag_q;

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      for (int r = 0; r < CoefNum; r++) begin
        for (int c = 0; c < CoefNum; c++) begin
          prod_q[r][c] <= coef_at(coef_q[r], c) * $signed({1'b0, tap_q[r][c]});
        end
      end
      s3_tag_q <= s2_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: one sum per kernel row
  // ---------------------------------------------------------------------------
  logic signed [RowW-1:0] row_sum_q [CoefNum];
  tag_t                   s4_tag_q;

  always_ff @(posedge clk_i) begin
    if (s3_go) begin
      for (int r = 0; r < CoefNum; r++) begin
        row_sum_q[r] <= RowW'(prod_q[r][0]) + RowW'(prod_q[r][1]) + RowW'(prod_q[r][2]);
      end
      s4_tag_q <= s3_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: total, drop the fraction, clamp into the output register
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0] sum;
  logic [SumW-1:0]        sum_int;
  pix_t                   res;
  pix_t                   pix_out_q;
  tag_t                   out_tag_q;

  always_comb begin
    sum     = SumW'(row_sum_q[0]) + SumW'(row_sum_q[1]) + SumW'(row_sum_q[2]);
    sum_int = $unsigned(sum) >> CoefFracBits;
    if (sum <= 0) begin
      res = '0;
    end else if (|sum_int[SumW-1:PixW]) begin
      res = '1;
    end else begin
      res = sum_int[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_go) begin
      pix_out_q <= res;
      out_tag_q <= s4_tag_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_emit_q <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q    <= 1'b1;
        s1_emit_q <= emit;
      end else if (s1_go) begin
        s1_v_q    <= 1'b0;
      end
      if (s1_go && s1_emit_q) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
      if (s2_go) begin
        s3_v_q <= 1'b1;
      end else if (s3_go) begin
        s3_v_q <= 1'b0;
      end
      if (s3_go) begin
        s4_v_q <= 1'b1;
      end else if (s4_go) begin
        s4_v_q <= 1'b0;
      end
      if (s4_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_out_o = pix_out_q;
  assign row_end_o   = out_tag_q.row_end;
  assign frame_end_o = out_tag_q.frame_end;

endmodule

FILE: rtl/conv3_chk.sv
// Port-level checker for conv3x3_zero_pad_clamp, bound to every instance.
// Depends on conv3_pkg for port widths.
module conv3_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [conv3_pkg::PixW-1:0] pixel_out_o,
  input logic                       row_end_o,
  input logic                       frame_end_o
);
  import conv3_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o)
      && $stable(row_end_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // The last pixel of a frame also closes its row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  // Refuse input only when a result waits at a blocked output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without output back-pressure");

  // Keep a refused input transaction on offer until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input withdrawn before acceptance");

endmodule

bind conv3x3_zero_pad_clamp conv3_chk u_conv3_chk (.*);

FILE: verif/conv3_tb_pkg.sv
// Scoreboard for the 3x3 convolution testbench: a bit-true predictor of the block
// and an in-order store of the results it should produce.
// Depends on conv3_pkg.
package conv3_tb_pkg;
  import conv3_pkg::*;

  localparam int unsigned ReportMax = 10;
  localparam int unsigned RowLimit  = (1 << DimW) - 1;
  localparam int unsigned PixMax    = (1 << PixW) - 1;

  typedef struct packed {
    pix_t pixel;
    tag_t tag;
  } conv_result_t;

  class conv_scoreboard;
    logic [CfgW-1:0]   kernel_row [CoefNum];
    logic [DimW-1:0]   width_reg;
    logic [DimW-1:0]   height_reg;
    logic [EntryW-1:0] line_mem [MaxWidthDef];
    pix_t              window [CoefNum][CoefNum];
    int unsigned       in_col, in_row, out_col, out_row;
    conv_result_t      expected [$];
    int unsigned       n_inputs, n_checked, n_errors, n_writes;

    function new();
      kernel_row[0] = CoefTopRst;
      kernel_row[1] = CoefMidRst;
      kernel_row[2] = CoefBotRst;
      width_reg     = WidthRst;
      height_reg    = HeightRst;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (window[r, c]) window[r][c] = '0;
      in_col    = 0;
      in_row    = 0;
      out_col   = 0;
      out_row   = 0;
      n_inputs  = 0;
      n_checked = 0;
      n_errors  = 0;
      n_writes  = 0;
    endfunction

    // Width 0 acts as 1, anything past the line store acts as its size
    function int unsigned frame_cols();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidthDef) return MaxWidthDef;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned frame_items();
      return frame_cols() * frame_rows() + frame_cols() + 1;
    endfunction

    function bit at_frame_start();
      return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
    endfunction

    function bit flushing();
      return in_row >= frame_rows();
    endfunction

    function int unsigned waiting();
      return expected.size();
    endfunction

    function void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      n_writes++;
      case (idx)
        CfgCoefTop: kernel_row[0] = data;
        CfgCoefMid: kernel_row[1] = data;
        CfgCoefBot: kernel_row[2] = data;
        CfgWidth:   width_reg     = data[DimW-1:0];
        CfgHeight:  height_reg    = data[DimW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the line store, window and counters by one pixel; queue a result if due
    function void note_pixel(pix_t pixel_in, logic pad);
      int unsigned       w, h, col, r, c;
      int                sum, tap, level;
      pix_t              px;
      logic [EntryW-1:0] entry;
      logic              fire;
      logic [2:0]        row_ok, col_ok;
      conv_result_t      res;
      w     = frame_cols();
      h     = frame_rows();
      px    = pad ? '0 : pixel_in;
      col   = (in_col < MaxWidthDef) ? in_col : MaxWidthDef - 1;
      entry = line_mem[col];
      fire  = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      n_inputs++;

      for (r = 0; r < CoefNum; r++) begin
        window[r][0] = window[r][1];
        window[r][1] = window[r][2];
      end
      window[0][2] = entry[EntryW-1:PixW];
      window[1][2] = entry[PixW-1:0];
      window[2][2] = px;
      line_mem[col] = {entry[PixW-1:0], px};

      if (in_col >= w - 1) begin
        in_col = 0;
        if (in_row < RowLimit) in_row++;
      end else begin
        in_col++;
      end
      if (!fire) return;

      res.tag.row_end   = (out_col >= w - 1);
      res.tag.frame_end = res.tag.row_end && (out_row >= h - 1);
      // bit 0 is the top row / left column
      row_ok = {out_row < h - 1, 1'b1, out_row != 0};
      col_ok = {out_col < w - 1, 1'b1, out_col != 0};
      sum = 0;
      for (r = 0; r < CoefNum; r++) begin
        for (c = 0; c < CoefNum; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            tap   = $signed(kernel_row[r][CoefW*c +: CoefW]);
            level = window[r][c];
            sum  += tap * level;
          end
        end
      end
      if (sum <= 0) res.pixel = '0;
      else if ((sum >>> CoefFracBitsDef) > PixMax) res.pixel = '1;
      else res.pixel = pix_t'(sum >>> CoefFracBitsDef);
      expected.push_back(res);

      if (res.tag.frame_end) begin
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
      end else if (res.tag.row_end) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    function void check_result(pix_t pixel, logic row_end, logic frame_end);
      conv_result_t want;
      n_checked++;
      if (expected.size() == 0) begin
        n_errors++;
        if (n_errors <= ReportMax)
          $display("ERROR: result %0d (pixel %0d row_end %0b frame_end %0b) with none expected",
                   n_checked, pixel, row_end, frame_end);
        return;
      end
      want = expected.pop_front();
      if (want.pixel !== pixel || want.tag.row_end !== row_end ||
          want.tag.frame_end !== frame_end) begin
        n_errors++;
        if (n_errors <= ReportMax)
          $display("ERROR: result %0d: expected pixel %0d row_end %0b frame_end %0b, %s %0d %0b %0b",
                   n_checked, want.pixel, want.tag.row_end, want.tag.frame_end,
                   "got", pixel, row_end, frame_end);
      end
    endfunction
  endclass

endpackage

FILE: verif/conv3x3_zero_pad_clamp_tb.sv
// Self-checking testbench for conv3x3_zero_pad_clamp: a few directed frames, then
// random frames with random kernels and sizes.
// Depends on conv3_pkg and conv3_tb_pkg.
module conv3x3_zero_pad_clamp_tb;
  import conv3_pkg::*;
  import conv3_tb_pkg::*;

  localparam int unsigned SettleCycles = 20;        // well past the pipeline depth
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned RandomItems  = 1500;
  localparam int unsigned CfgIdxLast   = (1 << CfgIdxW) - 1;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  pix_t                pixel_in_i  = '0;
  logic                is_pad_i    = 1'b0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  pix_t                pixel_out_o;
  logic                row_end_o;
  logic                frame_end_o;

  bit                  tx_gaps     = 1'b1;
  bit                  rx_stalls   = 1'b1;
  int unsigned         cycles      = 0;
  int unsigned         hold_off    = 0;
  int unsigned         mid_changes = 0;
  conv_scoreboard      sb;

  conv3x3_zero_pad_clamp u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .is_pad_i    (is_pad_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 12);
  endfunction

  // Result side: check every transaction, then hold ready low for a random stretch
  always @(posedge clk_i) begin : result_side
    int unsigned stall;
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(pixel_out_o, row_end_o, frame_end_o);
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end else begin
      stall = rx_stalls ? pick_gap() : 0;
      out_ready_i <= (stall == 0);
      hold_off    <= (stall == 0) ? 0 : stall - 1;
    end
  end

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return CoefW'($urandom);
      default: return CoefW'($urandom_range(0, 1024)) - CoefW'(512);
    endcase
  endfunction

  // Pack one kernel row: the left tap sits in the low bits
  function automatic logic [CfgW-1:0] kernel_row(input logic [CoefW-1:0] left, centre, right);
    return {right, centre, left};
  endfunction

  function automatic logic [CfgW-1:0] rand_row();
    return kernel_row(rand_coef(), rand_coef(), rand_coef());
  endfunction

  // Write one register; the caller drops the write enable after its last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.apply_write(idx, data);
  endtask

  // Stop sending, wait for every outstanding result, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Reprogram the whole block while idle; the spare indexes must be ignored
  task automatic setup(input logic [CfgW-1:0] top, mid, bot,
                       input logic [DimW-1:0] cols, rows);
    int unsigned idx;
    drain();
    write_reg(CfgCoefTop, top);
    write_reg(CfgCoefMid, mid);
    write_reg(CfgCoefBot, bot);
    write_reg(CfgWidth, CfgW'(cols));
    write_reg(CfgHeight, CfgW'(rows));
    for (idx = CfgHeight + 1; idx <= CfgIdxLast; idx++)
      write_reg(CfgIdxW'(idx), CfgW'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
  endtask

  // One input transaction; valid stays high across back-to-back pixels
  task automatic send_pixel(input pix_t pixel, input logic pad);
    int unsigned gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pixel;
    is_pad_i   <= pad;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(pixel, pad);
  endtask

  // Inside the image pads are rare; in the flush they are the rule, with stray pixels
  task automatic feed(input int unsigned pad_pct);
    logic pad;
    if (sb.flushing()) pad = ($urandom_range(0, 5) != 0);
    else pad = ($urandom_range(0, 99) < pad_pct);
    send_pixel(rand_pixel(), pad);
  endtask

  task automatic finish_frame(input int unsigned pad_pct);
    do feed(pad_pct); while (!sb.at_frame_start());
  endtask

  // Small random frame; now and then pause part-way and change the size under it
  task automatic random_frame();
    int unsigned cols, rows, pad_pct, split;
    cols      = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
    rows      = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
    pad_pct   = ($urandom_range(0, 3) == 0) ? 30 : 3;
    tx_gaps   = ($urandom_range(0, 4) != 0);
    rx_stalls = ($urandom_range(0, 4) != 0);
    setup(rand_row(), rand_row(), rand_row(), DimW'(cols), DimW'(rows));
    if ($urandom_range(0, 6) == 0) begin
      split = $urandom_range(1, sb.frame_items() - 1);
      repeat (split) feed(pad_pct);
      drain();
      // Narrow only once two full rows are stored, so every unmasked read hits a
      // written line-store entry; the height may move either way
      if (sb.in_row >= 2 && sb.frame_cols() > 1)
        write_reg(CfgWidth, CfgW'($urandom_range(1, sb.frame_cols() - 1)));
      else
        write_reg(CfgHeight, CfgW'($urandom_range(0, 8)));
      cfg_we_i <= 1'b0;
      mid_changes++;
    end
    finish_frame(pad_pct);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x3 box sum at 1.0 per tap: saturation at bright pixels, a pad inside the
    // frame, and a real pixel slipped into the flush
    setup(kernel_row(16'h0100, 16'h0100, 16'h0100), kernel_row(16'h0100, 16'h0100, 16'h0100),
          kernel_row(16'h0100, 16'h0100, 16'h0100), DimW'(3), DimW'(3));
    send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);   send_pixel(8'd1, 1'b0);   send_pixel(8'd255, 1'b1);
    send_pixel(8'd128, 1'b0); send_pixel(8'd255, 1'b0); send_pixel(8'd3, 1'b0);
    send_pixel(8'd0, 1'b1);   send_pixel(8'd200, 1'b0); send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b1);

    // Edge kernel, 2x2 frame: negative sums clamp to 0, the 8.5 centre tests truncation
    setup(kernel_row(16'hFF00, 16'hFF00, 16'hFF00), kernel_row(16'hFF00, 16'h0880, 16'hFF00),
          kernel_row(16'hFF00, 16'hFF00, 16'hFF00), DimW'(2), DimW'(2));
    send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b0);   send_pixel(8'd7, 1'b0);
    send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b1);   send_pixel(8'd0, 1'b1);
    send_pixel(8'd0, 1'b1);

    // Width and height of zero both act as one: a single-pixel frame
    setup('0, kernel_row(16'h0000, 16'h7FFF, 16'h0000), '0, '0, '0);
    send_pixel(8'd3, 1'b0);   send_pixel(8'd0, 1'b1);   send_pixel(8'd255, 1'b0);

    // Random frames, small sizes
    while (sb.n_inputs < RandomItems + 23) random_frame();

    drain();
    $display("Fed %0d pixel transactions, compared %0d results, %0d mismatches;",
             sb.n_inputs, sb.n_checked, sb.n_errors);
    $display("%0d register writes, %0d size changes part-way through a frame.",
             sb.n_writes, mid_changes);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
